// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the status reporter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define COSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never hold outside reset.
`define COSR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `COSR_ASSERT(lbl, clk, rst_n, (!(expr)), msg)

`endif

// ===== hw/rtl/cosr_pkg.sv =====
// ----------------------------------------------------------------------------
// cosr_pkg
// Types, constants and frame header lookup for the status reporter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cosr_pkg;

  localparam int NumSlots  = 5;
  localparam int NumTracks = 11;
  localparam int SlotW     = 3;

  localparam logic [15:0] PeriodReset     = 16'd5000;
  localparam logic [15:0] CountResetTop   = 16'd0;
  localparam logic [15:0] CountResetOther = 16'd15;
  localparam logic [7:0]  PowerLostCode   = 8'b0000_1110;
  localparam logic [7:0]  HdrEventTop     = 8'h41;
  localparam logic [7:0]  HdrEventBottom  = 8'h42;

  typedef enum logic [0:0] {
    REG_REFRESH_PERIOD = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]      count;
    logic [SlotW-1:0] slot;
    logic             force_send;
    logic             power_seen;
  } side_state_t;

  typedef logic [NumSlots-1:0][15:0] cache_row_t;

  typedef struct packed {
    side_state_t st;
    cache_row_t  cache;
  } mem_row_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] payload_byte;
    logic       last;
  } frame_word_t;

  typedef struct packed {
    frame_word_t w0;
    frame_word_t w1;
    logic [1:0]  count;
  } step_res_t;

  function automatic logic [7:0] slot_header(logic bottom, logic [SlotW-1:0] slot);
    logic [7:0] hdr;
    hdr = 8'h00;
    unique case (slot)
      3'd0:    hdr = bottom ? 8'h5A : 8'h4D;
      3'd1:    hdr = bottom ? 8'h59 : 8'h4C;
      3'd2:    hdr = bottom ? 8'h58 : 8'h4B;
      3'd3:    hdr = bottom ? 8'h57 : 8'h4A;
      3'd4:    hdr = bottom ? 8'h56 : 8'h49;
      default: hdr = 8'h00;
    endcase
    return hdr;
  endfunction

endpackage

// ===== hw/rtl/cosr_if.sv =====
// ----------------------------------------------------------------------------
// cosr_if
// Valid/ready channels for tick input words and frame output words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cosr_in_if;
  logic        valid;
  logic        ready;
  logic        side;
  logic [19:0] sensor_flags;
  logic [3:0]  track_number;
  logic [10:0] trains_on_tracks;
  logic        main_power;

  modport source (
    output valid, side, sensor_flags, track_number, trains_on_tracks, main_power,
    input  ready
  );
  modport sink (
    input  valid, side, sensor_flags, track_number, trains_on_tracks, main_power,
    output ready
  );
endinterface

interface cosr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic [7:0] payload_byte;
  logic       last;

  modport source (
    output valid, header_byte, payload_byte, last,
    input  ready
  );
  modport sink (
    input  valid, header_byte, payload_byte, last,
    output ready
  );
endinterface

// ===== hw/rtl/change_of_state_status_reporter_unit.sv =====
// ----------------------------------------------------------------------------
// change_of_state_status_reporter_unit
// Tick words arrive on in_i (valid/ready); each names a side and carries its
// sensor bits, track number, train flags and the main power bit. Every tick
// yields zero, one or two frame words on out_o: an optional power-lost event
// followed by an optional status frame, with last set on the final word.
// The refresh period register sits at APB byte address 0 (reset 5000).
// Per-side state and the five cached frames live in one RAM row per side.
// A tick's row is read at the edge that accepts it; its words reach out_o
// through the input register and the output buffer. One tick per cycle is
// sustained while each tick gives at most one word and the receiver is ready;
// a two-word tick makes the next one wait in the update stage. A forwarding
// register covers a tick of the same side that follows directly. After reset
// each row reads as its reset value until it is first written, so no clearing
// pass is needed. When the receiver stalls, the output buffer holds its
// words, one tick waits in the update stage and in_i.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module change_of_state_status_reporter_unit import cosr_pkg::*; #(
  parameter int NUM_SIDES = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cosr_in_if.sink     in_i,
  cosr_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SideW = (NUM_SIDES > 1) ? $clog2(NUM_SIDES) : 1;

  logic [15:0]      period_q;
  reg_idx_e         reg_idx;
  logic             cfg_we;

  logic             in_acc;
  logic             in_range;
  logic             s1_fire;
  logic             s1_valid_q;
  logic [SideW-1:0] s1_side_q;
  logic [19:0]      s1_sensor_q;
  logic [3:0]       s1_track_q;
  logic [10:0]      s1_trains_q;
  logic             s1_power_q;

  logic [NUM_SIDES-1:0] row_valid_q;
  logic                 fwd_valid_q;
  logic [SideW-1:0]     fwd_side_q;
  mem_row_t             fwd_row_q;

  logic [$bits(mem_row_t)-1:0] ram_rdata;
  mem_row_t  cur_row;
  mem_row_t  new_row;
  mem_row_t  reset_row;
  step_res_t res;
  logic      can_load;
  logic      ram_we;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_REFRESH_PERIOD);

  always_comb begin
    unique case (reg_idx)
      REG_REFRESH_PERIOD: prdata = {16'd0, period_q};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_we) begin
      period_q <= pwdata[15:0];
    end
  end

  // Input stage.
  assign in_range   = (32'(in_i.side) < NUM_SIDES);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_acc && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_side_q   <= SideW'(in_i.side);
      s1_sensor_q <= in_i.sensor_flags;
      s1_track_q  <= in_i.track_number;
      s1_trains_q <= in_i.trains_on_tracks;
      s1_power_q  <= in_i.main_power;
    end
  end

  cosr_ram #(
    .Width ($bits(mem_row_t)),
    .Depth (NUM_SIDES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_side_q),
    .wdata_i (new_row),
    .re_i    (in_acc),
    .raddr_i (SideW'(in_i.side)),
    .rdata_o (ram_rdata)
  );

  // Update stage.
  always_comb begin
    reset_row                = '0;
    reset_row.st.count       = (s1_side_q == '0) ? CountResetTop : CountResetOther;
    if (fwd_valid_q && (fwd_side_q == s1_side_q)) begin
      cur_row = fwd_row_q;
    end else if (row_valid_q[s1_side_q]) begin
      cur_row = mem_row_t'(ram_rdata);
    end else begin
      cur_row = reset_row;
    end
  end

  cosr_step u_step (
    .bottom_i           (s1_side_q != '0),
    .sensor_flags_i     (s1_sensor_q),
    .track_number_i     (s1_track_q),
    .trains_on_tracks_i (s1_trains_q),
    .main_power_i       (s1_power_q),
    .refresh_period_i   (period_q),
    .row_i              (cur_row),
    .row_o              (new_row),
    .res_o              (res)
  );

  assign s1_fire = s1_valid_q && ((res.count == 2'd0) || can_load);
  assign ram_we  = s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      fwd_valid_q <= 1'b0;
    end else if (ram_we) begin
      row_valid_q[s1_side_q] <= 1'b1;
      fwd_valid_q            <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_side_q <= s1_side_q;
      fwd_row_q  <= new_row;
    end
  end

  cosr_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s1_fire && (res.count != 2'd0)),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

  `COSR_ASSERT(a_s1_hold, clk_i, rst_ni, ((s1_valid_q && !s1_fire) |=> s1_valid_q),
               "stalled tick lost")
  `COSR_ASSERT(a_count_range, clk_i, rst_ni,
               (ram_we |-> ((new_row.st.count < period_q) || (new_row.st.count == 16'd0))),
               "refresh count beyond period")
  `COSR_ASSERT(a_slot_range, clk_i, rst_ni,
               (ram_we |-> (new_row.st.slot < SlotW'(NumSlots))), "frame slot out of range")

endmodule

// ===== hw/rtl/cosr_ram.sv =====
// ----------------------------------------------------------------------------
// cosr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cosr_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cosr_step.sv =====
// ----------------------------------------------------------------------------
// cosr_step
// Per-tick update of one side: refresh counter, power event, slot packing
// and change detection against the cached frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cosr_step import cosr_pkg::*; (
  input  logic        bottom_i,
  input  logic [19:0] sensor_flags_i,
  input  logic [3:0]  track_number_i,
  input  logic [10:0] trains_on_tracks_i,
  input  logic        main_power_i,
  input  logic [15:0] refresh_period_i,
  input  mem_row_t    row_i,
  output mem_row_t    row_o,
  output step_res_t   res_o
);

  localparam logic [SlotW-1:0] LastSlot = SlotW'(NumSlots - 1);
  localparam logic [SlotW-1:0] SlotCount = SlotW'(NumSlots);

  always_comb begin
    logic [15:0]      cnt_inc;
    logic             wrap;
    logic [SlotW-1:0] slot;
    logic             frc;
    logic             pseen;
    logic             evt;
    logic             send;
    logic [7:0]       hdr;
    logic [7:0]       pay;
    logic [19:0]      s;
    logic [10:0]      t;
    frame_word_t      evt_word;
    frame_word_t      stat_word;

    s       = sensor_flags_i;
    t       = trains_on_tracks_i;
    row_o   = row_i;
    cnt_inc = row_i.st.count + 16'd1;
    wrap    = (cnt_inc >= refresh_period_i);
    slot    = wrap ? '0 : row_i.st.slot;
    frc     = wrap | row_i.st.force_send;
    row_o.st.count = wrap ? 16'd0 : cnt_inc;

    evt   = !main_power_i && row_i.st.power_seen;
    pseen = main_power_i;

    hdr  = slot_header(bottom_i, slot);
    pay  = 8'h00;
    send = 1'b0;
    unique case (slot)
      3'd0:    pay = {s[0], s[1], s[2], s[3], s[4], s[5], s[6], 1'b1};
      3'd1:    pay = {track_number_i, s[7], s[8], (pseen ? s[9] : 1'b1), 1'b1};
      3'd2:    pay = {s[10], s[11], s[12], s[13], s[14], t[0], t[1], 1'b1};
      3'd3:    pay = {t[3], t[4], t[5], t[6], t[7], t[8], t[9], 1'b1};
      default: pay = {s[15], s[16], s[17], s[18], s[19], t[2], t[NumTracks-1], 1'b1};
    endcase

    if (slot < SlotCount) begin
      send = (row_i.cache[slot] != {hdr, pay}) || frc;
      if (send) begin
        row_o.cache[slot] = {hdr, pay};
        if (slot == LastSlot) begin
          frc = 1'b0;
        end
      end
      row_o.st.slot = (slot == LastSlot) ? '0 : slot + 1'b1;
    end else begin
      row_o.st.slot = '0;
    end
    row_o.st.force_send = frc;
    row_o.st.power_seen = pseen;

    evt_word.header_byte  = bottom_i ? HdrEventBottom : HdrEventTop;
    evt_word.payload_byte = PowerLostCode;
    evt_word.last         = !send;
    stat_word.header_byte  = hdr;
    stat_word.payload_byte = pay;
    stat_word.last         = 1'b1;

    res_o.w0    = evt ? evt_word : stat_word;
    res_o.w1    = stat_word;
    res_o.count = {1'b0, evt} + {1'b0, send};
  end

endmodule

// ===== hw/rtl/cosr_obuf.sv =====
// ----------------------------------------------------------------------------
// cosr_obuf
// Two-entry output buffer that takes the frames of one tick and hands them
// out one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cosr_obuf import cosr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  step_res_t         res_i,
  output logic              can_load_o,
  cosr_out_if.source        out_o
);

  frame_word_t head_q, head_d;
  frame_word_t tail_q, tail_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  assign pop        = (cnt_q != 2'd0) && out_o.ready;
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      head_d = res_i.w0;
      tail_d = res_i.w1;
      cnt_d  = res_i.count;
    end else if (pop) begin
      head_d = tail_q;
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.header_byte  = head_q.header_byte;
  assign out_o.payload_byte = head_q.payload_byte;
  assign out_o.last         = head_q.last;

  `COSR_ASSERT(a_load_room, clk_i, rst_ni, (load_i |-> can_load_o), "load without room")
  `COSR_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, (cnt_q == 2'd3), "buffer count overflow")

endmodule
